[rtl/core/assert_macros.svh]
// shared assertion forms, clocked on the rising edge and idle during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[rtl/core/vrrb_pkg.sv]
`timescale 1ns / 1ps

package vrrb_pkg;

   localparam int unsigned RING_WORDS       = 1024;
   localparam int unsigned LENGTH_ENTRIES   = 16;
   localparam int unsigned MAX_RECORD_WORDS = 64;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned RECLEN_W = 7;
   localparam int unsigned STATUS_W = 3;

   localparam int unsigned RING_AW = $clog2(RING_WORDS);
   localparam int unsigned LEN_AW  = $clog2(LENGTH_ENTRIES);

   typedef logic [RING_AW-1:0]  ring_addr_type;
   typedef logic [RING_AW:0]    ring_count_type;
   typedef logic [LEN_AW-1:0]   len_addr_type;
   typedef logic [LEN_AW:0]     len_count_type;
   typedef logic [RECLEN_W-1:0] rec_len_type;
   typedef logic [WORD_W-1:0]   word_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_TAKEN  = 3'd0,
      ST_COMMIT = 3'd1,
      ST_DROP   = 3'd2,
      ST_POP    = 3'd3,
      ST_EMPTY  = 3'd4
   } status_type;

   typedef struct packed {
      logic        strobe;
      status_type  status;
      word_type    word_out;
      logic        last_out;
      rec_len_type record_words;
   } rsp_type;

endpackage

[rtl/core/vrrb_ram.sv]
`timescale 1ns / 1ps

module vrrb_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/vrrb_ctrl.sv]
`timescale 1ns / 1ps

module vrrb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  vrrb_pkg::op_type         opcode,
   input  vrrb_pkg::word_type       word,
   input  logic                     last,
   output logic                     word_wr_en,
   output vrrb_pkg::ring_addr_type  word_wr_addr,
   output vrrb_pkg::word_type       word_wr_data,
   output logic                     word_rd_en,
   output vrrb_pkg::ring_addr_type  word_rd_addr,
   input  vrrb_pkg::word_type       word_rd_data,
   output logic                     len_wr_en,
   output vrrb_pkg::len_addr_type   len_wr_addr,
   output vrrb_pkg::rec_len_type    len_wr_data,
   output logic                     len_rd_en,
   output vrrb_pkg::len_addr_type   len_rd_addr,
   input  vrrb_pkg::rec_len_type    len_rd_data,
   output vrrb_pkg::rsp_type        rsp
);

   import vrrb_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LEN,
      S_READ,
      S_DRAIN
   } state_type;

   localparam ring_count_type RING_CNT = ring_count_type'(RING_WORDS);
   localparam len_count_type  LEN_CNT  = len_count_type'(LENGTH_ENTRIES);
   localparam rec_len_type    MAX_LEN  = rec_len_type'(MAX_RECORD_WORDS);
   localparam rec_len_type    ONE_LEN  = rec_len_type'(1);

   state_type      state_ff,    state_in;
   ring_addr_type  wp_addr_ff,  wp_addr_in;
   logic           wp_wrap_ff,  wp_wrap_in;
   ring_addr_type  rp_addr_ff,  rp_addr_in;
   logic           rp_wrap_ff,  rp_wrap_in;
   len_addr_type   lw_addr_ff,  lw_addr_in;
   logic           lw_wrap_ff,  lw_wrap_in;
   len_addr_type   lr_addr_ff,  lr_addr_in;
   logic           lr_wrap_ff,  lr_wrap_in;
   rec_len_type    pending_ff,  pending_in;
   logic           dropping_ff, dropping_in;
   rec_len_type    len_ff,      len_in;
   rec_len_type    remain_ff,   remain_in;
   logic           rd_pend_ff,  rd_pend_in;
   logic           rd_last_ff,  rd_last_in;
   rsp_type        rsp_ff,      rsp_in;

   ring_count_type stored_c;
   len_count_type  records_c;
   rec_len_type    newlen_c;
   rec_len_type    poplen_c;
   logic           drop_c;
   ring_count_type wsum_c;
   ring_count_type csum_c;
   ring_addr_type  wr_addr_c;

   always_comb begin
      if (wp_wrap_ff == rp_wrap_ff) begin
         stored_c = ring_count_type'(wp_addr_ff) - ring_count_type'(rp_addr_ff);
      end else begin
         stored_c = ring_count_type'(wp_addr_ff) + RING_CNT - ring_count_type'(rp_addr_ff);
      end
      if (lw_wrap_ff == lr_wrap_ff) begin
         records_c = len_count_type'(lw_addr_ff) - len_count_type'(lr_addr_ff);
      end else begin
         records_c = len_count_type'(lw_addr_ff) + LEN_CNT - len_count_type'(lr_addr_ff);
      end

      newlen_c = pending_ff + ONE_LEN;
      drop_c   = (newlen_c > MAX_LEN)
              || ((RING_AW + 2)'(stored_c) + (RING_AW + 2)'(newlen_c)
                  > (RING_AW + 2)'(RING_WORDS))
              || (last && (records_c == LEN_CNT));

      // staged word lands past the committed write pointer
      wsum_c = ring_count_type'(wp_addr_ff) + ring_count_type'(pending_ff);
      if (wsum_c >= RING_CNT) begin
         wr_addr_c = ring_addr_type'(wsum_c - RING_CNT);
      end else begin
         wr_addr_c = ring_addr_type'(wsum_c);
      end
      csum_c = ring_count_type'(wp_addr_ff) + ring_count_type'(newlen_c);

      if (len_rd_data == '0) begin
         poplen_c = ONE_LEN;
      end else if (len_rd_data > MAX_LEN) begin
         poplen_c = MAX_LEN;
      end else begin
         poplen_c = len_rd_data;
      end
   end

   always_comb begin
      state_in    = state_ff;
      wp_addr_in  = wp_addr_ff;
      wp_wrap_in  = wp_wrap_ff;
      rp_addr_in  = rp_addr_ff;
      rp_wrap_in  = rp_wrap_ff;
      lw_addr_in  = lw_addr_ff;
      lw_wrap_in  = lw_wrap_ff;
      lr_addr_in  = lr_addr_ff;
      lr_wrap_in  = lr_wrap_ff;
      pending_in  = pending_ff;
      dropping_in = dropping_ff;
      len_in      = len_ff;
      remain_in   = remain_ff;
      rd_pend_in  = 1'b0;
      rd_last_in  = rd_last_ff;
      rsp_in      = '0;
      word_wr_en  = 1'b0;
      word_rd_en  = 1'b0;
      len_wr_en   = 1'b0;
      len_rd_en   = 1'b0;

      // popped word comes back in the cycle after its read
      if (rd_pend_ff) begin
         rsp_in.strobe       = 1'b1;
         rsp_in.status       = ST_POP;
         rsp_in.word_out     = word_rd_data;
         rsp_in.last_out     = rd_last_ff;
         rsp_in.record_words = len_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in.strobe   = 1'b1;
               rsp_in.last_out = 1'b1;
               if (opcode == OP_PUSH) begin
                  if (dropping_ff) begin
                     dropping_in   = ~last;
                     rsp_in.status = ST_DROP;
                  end else if (drop_c) begin
                     pending_in    = '0;
                     dropping_in   = ~last;
                     rsp_in.status = ST_DROP;
                  end else begin
                     word_wr_en = 1'b1;
                     if (last) begin
                        len_wr_en = 1'b1;
                        if (len_count_type'(lw_addr_ff) + len_count_type'(1) == LEN_CNT) begin
                           lw_addr_in = '0;
                           lw_wrap_in = ~lw_wrap_ff;
                        end else begin
                           lw_addr_in = lw_addr_ff + len_addr_type'(1);
                        end
                        if (csum_c >= RING_CNT) begin
                           wp_addr_in = ring_addr_type'(csum_c - RING_CNT);
                           wp_wrap_in = ~wp_wrap_ff;
                        end else begin
                           wp_addr_in = ring_addr_type'(csum_c);
                        end
                        pending_in          = '0;
                        rsp_in.status       = ST_COMMIT;
                        rsp_in.record_words = newlen_c;
                     end else begin
                        pending_in    = newlen_c;
                        rsp_in.status = ST_TAKEN;
                     end
                  end
               end else begin
                  if (records_c == '0) begin
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     // no beat yet, the record length comes first
                     rsp_in    = '0;
                     len_rd_en = 1'b1;
                     state_in  = S_LEN;
                  end
               end
            end
         end
         S_LEN: begin
            word_rd_en = 1'b1;
            len_in     = poplen_c;
            remain_in  = poplen_c - ONE_LEN;
            rd_pend_in = 1'b1;
            rd_last_in = (poplen_c == ONE_LEN);
            if (len_count_type'(lr_addr_ff) + len_count_type'(1) == LEN_CNT) begin
               lr_addr_in = '0;
               lr_wrap_in = ~lr_wrap_ff;
            end else begin
               lr_addr_in = lr_addr_ff + len_addr_type'(1);
            end
            state_in = (poplen_c == ONE_LEN) ? S_DRAIN : S_READ;
         end
         S_READ: begin
            word_rd_en = 1'b1;
            remain_in  = remain_ff - ONE_LEN;
            rd_pend_in = 1'b1;
            rd_last_in = (remain_ff == ONE_LEN);
            if (remain_ff == ONE_LEN) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (word_rd_en) begin
         if (ring_count_type'(rp_addr_ff) + ring_count_type'(1) == RING_CNT) begin
            rp_addr_in = '0;
            rp_wrap_in = ~rp_wrap_ff;
         end else begin
            rp_addr_in = rp_addr_ff + ring_addr_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         wp_addr_ff  <= '0;
         wp_wrap_ff  <= 1'b0;
         rp_addr_ff  <= '0;
         rp_wrap_ff  <= 1'b0;
         lw_addr_ff  <= '0;
         lw_wrap_ff  <= 1'b0;
         lr_addr_ff  <= '0;
         lr_wrap_ff  <= 1'b0;
         pending_ff  <= '0;
         dropping_ff <= 1'b0;
         rd_pend_ff  <= 1'b0;
         rsp_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         wp_addr_ff  <= wp_addr_in;
         wp_wrap_ff  <= wp_wrap_in;
         rp_addr_ff  <= rp_addr_in;
         rp_wrap_ff  <= rp_wrap_in;
         lw_addr_ff  <= lw_addr_in;
         lw_wrap_ff  <= lw_wrap_in;
         lr_addr_ff  <= lr_addr_in;
         lr_wrap_ff  <= lr_wrap_in;
         pending_ff  <= pending_in;
         dropping_ff <= dropping_in;
         rd_pend_ff  <= rd_pend_in;
         rsp_ff      <= rsp_in;
      end
      len_ff     <= len_in;
      remain_ff  <= remain_in;
      rd_last_ff <= rd_last_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign word_wr_addr = wr_addr_c;
   assign word_wr_data = word;
   assign word_rd_addr = rp_addr_ff;
   assign len_wr_addr  = lw_addr_ff;
   assign len_wr_data  = newlen_c;
   assign len_rd_addr  = lr_addr_ff;
   assign rsp          = rsp_ff;

endmodule

[rtl/core/variable_record_ring_buffer.sv]
// channel   direction  handshake              beat
// req_*     in         start high, busy low   opcode, word, last
// rsp_*     out        rsp_strobe, one cycle  status, word_out, last_out, record_words
//
// push: busy stays low, its result shows in the next cycle.
// empty pop: busy stays low, one result in the next cycle.
// pop of n words: length ring read, then one word per cycle off the word ram read
// port; busy through the S_LEN, S_READ and S_DRAIN states, first beat after the length
// ram, word ram and response registers, then one per cycle, the last one in the first cycle with busy low again.
// reset clears pointers, counts and the drop flag; the rams are not cleared.
// results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module variable_record_ring_buffer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [vrrb_pkg::WORD_W-1:0]         req_word,
   input  logic                                req_last,
   output logic                                rsp_strobe,
   output logic [vrrb_pkg::STATUS_W-1:0]       rsp_status,
   output logic [vrrb_pkg::WORD_W-1:0]         rsp_word_out,
   output logic                                rsp_last_out,
   output logic [vrrb_pkg::RECLEN_W-1:0]       rsp_record_words
);

   import vrrb_pkg::*;

   logic          word_wr_en;
   ring_addr_type word_wr_addr;
   word_type      word_wr_data;
   logic          word_rd_en;
   ring_addr_type word_rd_addr;
   word_type      word_rd_data;
   logic          len_wr_en;
   len_addr_type  len_wr_addr;
   rec_len_type   len_wr_data;
   logic          len_rd_en;
   len_addr_type  len_rd_addr;
   rec_len_type   len_rd_data;
   rsp_type       rsp;

   vrrb_ram #(
      .DEPTH (RING_WORDS),
      .WIDTH (WORD_W)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (word_wr_en),
      .wr_addr (word_wr_addr),
      .wr_data (word_wr_data),
      .rd_en   (word_rd_en),
      .rd_addr (word_rd_addr),
      .rd_data (word_rd_data)
   );

   vrrb_ram #(
      .DEPTH (LENGTH_ENTRIES),
      .WIDTH (RECLEN_W)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (len_wr_addr),
      .wr_data (len_wr_data),
      .rd_en   (len_rd_en),
      .rd_addr (len_rd_addr),
      .rd_data (len_rd_data)
   );

   vrrb_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .opcode       (op_type'(req_opcode)),
      .word         (req_word),
      .last         (req_last),
      .word_wr_en   (word_wr_en),
      .word_wr_addr (word_wr_addr),
      .word_wr_data (word_wr_data),
      .word_rd_en   (word_rd_en),
      .word_rd_addr (word_rd_addr),
      .word_rd_data (word_rd_data),
      .len_wr_en    (len_wr_en),
      .len_wr_addr  (len_wr_addr),
      .len_wr_data  (len_wr_data),
      .len_rd_en    (len_rd_en),
      .len_rd_addr  (len_rd_addr),
      .len_rd_data  (len_rd_data),
      .rsp          (rsp)
   );

   assign rsp_strobe       = rsp.strobe;
   assign rsp_status       = rsp.status;
   assign rsp_word_out     = rsp.word_out;
   assign rsp_last_out     = rsp.last_out;
   assign rsp_record_words = rsp.record_words;

   `ASSERT_CLK(a_push_answers, (start && !busy && req_opcode == OP_PUSH) |=> rsp_strobe, "push without result")
   `ASSERT_CLK(a_pop_progress, (start && !busy && req_opcode == OP_POP) |=> (rsp_strobe || busy), "pop neither answered nor started")
   `ASSERT_NEVER(a_word_only_on_pop, rsp_strobe && rsp_status != ST_POP && rsp_word_out != '0, "data word on non-pop beat")
   `ASSERT_NEVER(a_len_bound, rsp_strobe && rsp_record_words > RECLEN_W'(MAX_RECORD_WORDS), "record length out of range")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import vrrb_pkg::*;

   localparam int WORD_SPAN   = 2 * RING_WORDS;
   localparam int LEN_SPAN    = 2 * LENGTH_ENTRIES;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 80;

   typedef struct {
      status_type  status;
      word_type    word;
      logic        last;
      rec_len_type words;
   } rsp_beat_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_opcode;
   word_type            req_word;
   logic                req_last;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   word_type            rsp_word_out;
   logic                rsp_last_out;
   rec_len_type         rsp_record_words;

   variable_record_ring_buffer uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_word         (req_word),
      .req_last         (req_last),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_word_out     (rsp_word_out),
      .rsp_last_out     (rsp_last_out),
      .rsp_record_words (rsp_record_words)
   );

   // mirror of the buffer contents and pointers
   word_type     ring_words [RING_WORDS];
   rec_len_type  ring_lengths [LENGTH_ENTRIES];
   int           wr_ptr;
   int           rd_ptr;
   int           staged;
   int           len_wr;
   int           len_rd;
   bit           discarding;

   rsp_beat_type expected_beats [$];
   int           mismatches;
   int           quiet_cycles;
   int           sender_gap_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void add_expected(status_type s, word_type w, logic l, int n);
      rsp_beat_type b;
      b.status = s;
      b.word   = w;
      b.last   = l;
      b.words  = rec_len_type'(n);
      expected_beats.push_back(b);
   endfunction

   function automatic void predict_push(word_type w, logic lst);
      int stored;
      int records;
      int newlen;
      stored  = (wr_ptr - rd_ptr + WORD_SPAN) % WORD_SPAN;
      records = (len_wr - len_rd + LEN_SPAN) % LEN_SPAN;
      if (discarding) begin
         if (lst)
            discarding = 1'b0;
         add_expected(ST_DROP, '0, 1'b1, 0);
         return;
      end
      newlen = staged + 1;
      if (newlen > MAX_RECORD_WORDS || stored + newlen > RING_WORDS ||
          (lst && records >= LENGTH_ENTRIES)) begin
         staged     = 0;
         discarding = !lst;
         add_expected(ST_DROP, '0, 1'b1, 0);
         return;
      end
      ring_words[(wr_ptr + staged) % RING_WORDS] = w;
      if (lst) begin
         ring_lengths[len_wr % LENGTH_ENTRIES] = rec_len_type'(newlen);
         len_wr = (len_wr + 1) % LEN_SPAN;
         wr_ptr = (wr_ptr + newlen) % WORD_SPAN;
         staged = 0;
         add_expected(ST_COMMIT, '0, 1'b1, newlen);
      end else begin
         staged = newlen;
         add_expected(ST_TAKEN, '0, 1'b1, 0);
      end
   endfunction

   function automatic void predict_pop();
      int n;
      if (len_wr == len_rd) begin
         add_expected(ST_EMPTY, '0, 1'b1, 0);
         return;
      end
      n = ring_lengths[len_rd % LENGTH_ENTRIES];
      for (int i = 0; i < n; i++) begin
         add_expected(ST_POP, ring_words[rd_ptr % RING_WORDS], i == n - 1, n);
         rd_ptr = (rd_ptr + 1) % WORD_SPAN;
      end
      len_rd = (len_rd + 1) % LEN_SPAN;
   endfunction

   // start stays high after a beat so back-to-back beats need no extra edge
   task automatic send_beat(op_type op, word_type w, logic lst);
      if ($urandom_range(99) < sender_gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start      <= 1'b1;
      req_opcode <= op;
      req_word   <= w;
      req_last   <= lst;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (op == OP_PUSH)
         predict_push(w, lst);
      else
         predict_pop();
   endtask

   task automatic push_record(int n);
      for (int i = 0; i < n; i++)
         send_beat(OP_PUSH, $urandom(), i == n - 1);
   endtask

   // close any open record, pop everything, then wait for the last beat
   task automatic settle_buffer();
      if (staged != 0 || discarding)
         send_beat(OP_PUSH, $urandom(), 1'b1);
      while (len_wr != len_rd)
         send_beat(OP_POP, $urandom(), 1'b0);
      start <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed();
      send_beat(OP_POP, '0, 1'b0);
      send_beat(OP_PUSH, 32'h0000_0000, 1'b1);
      send_beat(OP_PUSH, 32'hFFFF_FFFF, 1'b0);
      send_beat(OP_PUSH, 32'hA5A5_A5A5, 1'b0);
      send_beat(OP_PUSH, 32'h5A5A_5A5A, 1'b1);
      // open record stays invisible to pops
      send_beat(OP_PUSH, 32'h8000_0001, 1'b0);
      send_beat(OP_POP, '1, 1'b1);
      send_beat(OP_POP, '0, 1'b0);
      send_beat(OP_POP, '1, 1'b0);
      send_beat(OP_PUSH, 32'h7FFF_FFFE, 1'b1);
      send_beat(OP_POP, '0, 1'b1);
      send_beat(OP_POP, '0, 1'b0);
   endtask

   task automatic test_too_long();
      // overflow mid-record, rest of it discarded
      push_record(MAX_RECORD_WORDS + 2);
      push_record(2);
      settle_buffer();
   endtask

   task automatic test_length_ring_full();
      settle_buffer();
      repeat (LENGTH_ENTRIES)
         push_record(1);
      // drop on the last beat leaves no discard state behind
      push_record(2);
      push_record(1);
      send_beat(OP_POP, $urandom(), 1'b0);
      push_record(1);
      settle_buffer();
   endtask

   task automatic test_random(int n_beats);
      int sent;
      int pick;
      int n;
      sent = 0;
      while (sent < n_beats) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_beat(OP_POP, $urandom(), 1'($urandom_range(1)));
            sent++;
         end else if (pick < 85) begin
            n = $urandom_range(1, 6);
            push_record(n);
            sent += n;
         end else begin
            send_beat(op_type'($urandom_range(1)), $urandom(), 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_beat_type exp_beat;
      if (!reset && rsp_strobe) begin
         if (expected_beats.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected beat: status %0d word %h last %b len %0d",
                        rsp_status, rsp_word_out, rsp_last_out, rsp_record_words);
            mismatches++;
         end else begin
            exp_beat = expected_beats.pop_front();
            if (rsp_status !== exp_beat.status || rsp_word_out !== exp_beat.word ||
                rsp_last_out !== exp_beat.last || rsp_record_words !== exp_beat.words) begin
               if (mismatches < 10)
                  $display({"mismatch: expected status %0d word %h last %b len %0d, ",
                            "got status %0d word %h last %b len %0d"},
                           exp_beat.status, exp_beat.word, exp_beat.last, exp_beat.words,
                           rsp_status, rsp_word_out, rsp_last_out, rsp_record_words);
               mismatches++;
            end
         end
      end
   end

   // stall watchdog: no beat in and none out for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("variable_record_ring_buffer verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_opcode     <= OP_PUSH;
      req_word       <= '0;
      req_last       <= 1'b0;
      mismatches     = 0;
      sender_gap_pct = 31;
      wr_ptr         = 0;
      rd_ptr         = 0;
      staged         = 0;
      len_wr         = 0;
      len_rd         = 0;
      discarding     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_too_long();
      test_random(6);

      sender_gap_pct = 86;
      test_length_ring_full();
      test_random(6);

      sender_gap_pct = 0;
      test_random(10);

      start <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("variable_record_ring_buffer verification clean");
      end else begin
         $display("variable_record_ring_buffer verification failed");
      end
      $finish;
   end

endmodule
